@@ hdl/hsc_pkg.sv @@
package hsc_pkg;

   // Field widths of the request and response transactions.
   localparam int TYPE_W   = 2;
   localparam int ROW_W    = 4;
   localparam int LETTER_W = 6;
   localparam int BYTE_W   = 8;

   // Request type codes.
   localparam logic [TYPE_W-1:0] REQ_LOAD_PLAIN  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_LOAD_CIPHER = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_ENCRYPT     = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_DECRYPT     = 2'd3;

   // Case rows of the plain alphabet.
   localparam logic [ROW_W-1:0] UPPER_ROW = 4'd0;
   localparam logic [ROW_W-1:0] LOWER_ROW = 4'd1;

   // One request as held in the input register.
   typedef struct packed {
      logic [TYPE_W-1:0]   req_type;
      logic [ROW_W-1:0]    row;
      logic [LETTER_W-1:0] letter;
      logic [BYTE_W-1:0]   char_byte;
      logic                text_start;
   } req_item_type;

   // Control broadcast from the top level to every letter lane.
   typedef struct packed {
      logic                advance;
      logic                clear;
      logic [TYPE_W-1:0]   op;
      logic [ROW_W-1:0]    row;
      logic [LETTER_W-1:0] letter;
      logic [BYTE_W-1:0]   char_byte;
   } lane_ctl_type;

   // One response as held in the output register.
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              matched;
   } rsp_item_type;

endpackage

@@ hdl/hsc_if.sv @@
// Request channel.
interface hsc_req_if import hsc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [TYPE_W-1:0]   req_type;
   logic [ROW_W-1:0]    row;
   logic [LETTER_W-1:0] letter;
   logic [BYTE_W-1:0]   char_byte;
   logic                text_start;

   modport source (
      output valid, req_type, row, letter, char_byte, text_start,
      input  ready
   );
   modport sink (
      input  valid, req_type, row, letter, char_byte, text_start,
      output ready
   );
endinterface

// Response channel.
interface hsc_rsp_if import hsc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              matched;

   modport source (
      output valid, out_byte, matched,
      input  ready
   );
   modport sink (
      input  valid, out_byte, matched,
      output ready
   );
endinterface

@@ hdl/hsc_letter_lane.sv @@
module hsc_letter_lane import hsc_pkg::*; #(
   parameter int LANE       = 0,
   parameter int HOMOPHONES = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  lane_ctl_type      ctl,
   output logic              match,
   output logic [BYTE_W-1:0] cand_byte
);

   localparam int CW = (HOMOPHONES > 1) ? $clog2(HOMOPHONES) : 1;
   localparam logic [LETTER_W-1:0] LANE_ID   = LETTER_W'(LANE);
   localparam logic [ROW_W:0]      CIPH_ROWS = (ROW_W+1)'(HOMOPHONES);
   localparam logic [CW-1:0]       LAST_CNT  = CW'(HOMOPHONES - 1);

   logic [BYTE_W-1:0] upper_ff;
   logic [BYTE_W-1:0] lower_ff;
   logic [BYTE_W-1:0] column_ff [HOMOPHONES];
   logic [CW-1:0]     cnt_ff;
   logic [CW-1:0]     cnt_in;

   logic              this_lane;
   logic [CW-1:0]     cur_cnt;
   logic [CW-1:0]     next_cnt;
   logic [BYTE_W-1:0] expect_byte;
   logic              enc_hit;
   logic              dec_hit;

   assign this_lane = ctl.advance && (ctl.letter == LANE_ID);

   // Table loads for this letter column.
   always_ff @(posedge clock) begin
      if (this_lane && ctl.op == REQ_LOAD_PLAIN && ctl.row == UPPER_ROW) begin
         upper_ff <= ctl.char_byte;
      end
      if (this_lane && ctl.op == REQ_LOAD_PLAIN && ctl.row == LOWER_ROW) begin
         lower_ff <= ctl.char_byte;
      end
      if (this_lane && ctl.op == REQ_LOAD_CIPHER && {1'b0, ctl.row} < CIPH_ROWS) begin
         column_ff[ctl.row[CW-1:0]] <= ctl.char_byte;
      end
   end

   // A text start clears the counter before the byte is compared.
   assign cur_cnt     = ctl.clear ? '0 : cnt_ff;
   assign next_cnt    = (cur_cnt == LAST_CNT) ? '0 : cur_cnt + CW'(1);
   assign expect_byte = column_ff[cur_cnt];

   // Match against either case for encrypt, against the current homophone for decrypt.
   assign enc_hit   = (ctl.char_byte == upper_ff) || (ctl.char_byte == lower_ff);
   assign dec_hit   = (ctl.char_byte == expect_byte);
   assign match     = ((ctl.op == REQ_ENCRYPT) && enc_hit) ||
                      ((ctl.op == REQ_DECRYPT) && dec_hit);
   assign cand_byte = (ctl.op == REQ_ENCRYPT) ? expect_byte : upper_ff;

   // Counter advances on a match, otherwise keeps its (possibly cleared) value.
   always_comb begin
      cnt_in = cnt_ff;
      if (ctl.advance) begin
         cnt_in = match ? next_cnt : cur_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ hdl/hsc_select.sv @@
module hsc_select import hsc_pkg::*; #(
   parameter int LETTERS = 33
) (
   input  logic [LETTERS-1:0] match,
   input  logic [BYTE_W-1:0]  cand_byte [LETTERS],
   input  logic [BYTE_W-1:0]  pass_byte,
   output rsp_item_type       result
);

   logic [LETTERS-1:0] pick;
   logic [BYTE_W-1:0]  merged;

   // A lane wins when it matches and no higher lane does.
   for (genvar i = 0; i < LETTERS; i++) begin : g_pick
      if (i == LETTERS - 1) begin : g_top
         assign pick[i] = match[i];
      end else begin : g_rest
         assign pick[i] = match[i] && !(|match[LETTERS-1:i+1]);
      end
   end

   // At most one pick bit is set, so an OR of the gated bytes is the mux.
   always_comb begin
      merged = '0;
      for (int i = 0; i < LETTERS; i++) begin
         merged = merged | ({BYTE_W{pick[i]}} & cand_byte[i]);
      end
   end

   assign result.matched  = |match;
   assign result.out_byte = (|match) ? merged : pass_byte;

endmodule

@@ hdl/homophonic_substitution_cipher.sv @@
// Channel  Dir  Handshake    Payload
// req_ch   in   valid/ready  req_type, row, letter, char_byte, text_start
// rsp_ch   out  valid/ready  out_byte, matched
//
// One transaction per cycle is accepted, unless a text transaction waits on a stalled
// response. A transaction is held in the input register, where all letter lanes compare
// it and update their counters; an encrypt or decrypt response is registered from there
// into the output register once that register is free, and can then be taken.
// The lane compare with its counter feedback, and the priority select into the output
// register, set the cycle.
// Reset clears the letter counters and both valid flags; the tables hold nothing
// defined until loaded. A stalled response holds the input register only when it
// carries text; loads always pass through.
module homophonic_substitution_cipher import hsc_pkg::*; #(
   parameter int LETTERS    = 33,
   parameter int HOMOPHONES = 12
) (
   input  logic        clock,
   input  logic        reset,
   hsc_req_if.sink     req_ch,
   hsc_rsp_if.source   rsp_ch
);

   req_item_type      item_ff;
   logic              item_valid_ff;
   logic              item_valid_in;
   rsp_item_type      rsp_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;

   logic              item_is_text;
   logic              out_free;
   logic              advance;
   lane_ctl_type      ctl;
   logic [LETTERS-1:0] lane_match;
   logic [BYTE_W-1:0] lane_cand [LETTERS];
   rsp_item_type      result;

   // Handshake between the input register and the output register.
   assign item_is_text = (item_ff.req_type == REQ_ENCRYPT) ||
                         (item_ff.req_type == REQ_DECRYPT);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = item_valid_ff && (!item_is_text || out_free);
   assign req_ch.ready = !item_valid_ff || advance;

   // Input register.
   assign item_valid_in = (req_ch.valid && req_ch.ready) || (item_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         item_ff.req_type   <= req_ch.req_type;
         item_ff.row        <= req_ch.row;
         item_ff.letter     <= req_ch.letter;
         item_ff.char_byte  <= req_ch.char_byte;
         item_ff.text_start <= req_ch.text_start;
      end
   end

   // Control broadcast to the lanes.
   assign ctl.advance   = advance;
   assign ctl.clear     = item_ff.text_start;
   assign ctl.op        = item_ff.req_type;
   assign ctl.row       = item_ff.row;
   assign ctl.letter    = item_ff.letter;
   assign ctl.char_byte = item_ff.char_byte;

   for (genvar i = 0; i < LETTERS; i++) begin : g_lane
      hsc_letter_lane #(
         .LANE       (i),
         .HOMOPHONES (HOMOPHONES)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .match     (lane_match[i]),
         .cand_byte (lane_cand[i])
      );
   end

   hsc_select #(
      .LETTERS (LETTERS)
   ) u_select (
      .match     (lane_match),
      .cand_byte (lane_cand),
      .pass_byte (item_ff.char_byte),
      .result    (result)
   );

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && item_is_text) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && item_is_text) begin
         rsp_ff <= result;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_byte = rsp_ff.out_byte;
   assign rsp_ch.matched  = rsp_ff.matched;

endmodule

@@ hdl/hsc_checker.sv @@
module hsc_checker import hsc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   hsc_req_if.sink   req_ch,
   hsc_rsp_if.source rsp_ch
);

   logic req_fire;
   logic req_text;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign req_text = req_fire &&
                     ((req_ch.req_type == REQ_ENCRYPT) || (req_ch.req_type == REQ_DECRYPT));

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=>
         rsp_ch.valid && $stable(rsp_ch.out_byte) && $stable(rsp_ch.matched))
      else $error("response changed while stalled");

   // Coming out of reset, no response is pending and requests are taken.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid && req_ch.ready)
      else $error("block not idle after reset");

   // No response appears without a recent request transaction.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_ch.valid && !req_fire && !$past(req_fire) |=> !rsp_ch.valid)
      else $error("response without a request");

   // A text transaction yields a response once the output side has room.
   a_text_result: assert property (@(posedge clock) disable iff (reset)
      req_text ##1 (!rsp_ch.valid || rsp_ch.ready) |=> rsp_ch.valid)
      else $error("text transaction produced no response");

endmodule

bind homophonic_substitution_cipher hsc_checker u_hsc_checker (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch)
);

@@ test/hsc_cipher_checker.sv @@
module hsc_cipher_checker import hsc_pkg::*; #(
   parameter int LETTERS    = 33,
   parameter int HOMOPHONES = 12
) (
   input  logic clock,
   input  logic reset,
   hsc_req_if   req_mon,
   hsc_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   pending_count
);

   // Mirror of the alphabet, the homophone table and the per-letter counters.
   logic [BYTE_W-1:0] plain_copy      [2][LETTERS];
   logic [BYTE_W-1:0] cipher_copy     [HOMOPHONES][LETTERS];
   logic [ROW_W-1:0]  homophone_count [LETTERS];

   // Responses still owed by the block, oldest first.
   rsp_item_type expected_text_q [$];

   // Applies one request to the mirror and returns 1 when it owes a response.
   function automatic bit apply_request(input req_item_type rq, output rsp_item_type rs);
      int unsigned       cur;
      logic [BYTE_W-1:0] homophone;
      bit                hit;
      rs.out_byte = rq.char_byte;
      rs.matched  = 1'b0;
      if (rq.text_start) begin
         foreach (homophone_count[i]) homophone_count[i] = '0;
      end
      case (rq.req_type)
         REQ_LOAD_PLAIN: begin
            if (rq.row <= LOWER_ROW && rq.letter < LETTERS)
               plain_copy[rq.row][rq.letter] = rq.char_byte;
            return 1'b0;
         end
         REQ_LOAD_CIPHER: begin
            if (rq.row < HOMOPHONES && rq.letter < LETTERS)
               cipher_copy[rq.row][rq.letter] = rq.char_byte;
            return 1'b0;
         end
         default: begin
            // Every letter is compared; the highest matching letter answers.
            for (int i = 0; i < LETTERS; i++) begin
               cur       = (homophone_count[i] < HOMOPHONES) ? homophone_count[i] : 0;
               homophone = cipher_copy[cur][i];
               if (rq.req_type == REQ_ENCRYPT)
                  hit = (rq.char_byte == plain_copy[UPPER_ROW][i]) ||
                        (rq.char_byte == plain_copy[LOWER_ROW][i]);
               else
                  hit = (rq.char_byte == homophone);
               if (hit) begin
                  rs.out_byte = (rq.req_type == REQ_ENCRYPT) ? homophone
                                                             : plain_copy[UPPER_ROW][i];
                  rs.matched  = 1'b1;
                  homophone_count[i] = (cur + 1 >= HOMOPHONES) ? '0 : ROW_W'(cur + 1);
               end
            end
            return 1'b1;
         end
      endcase
   endfunction

   // Counts a failure and reports the first ten of them.
   task automatic flag_mismatch(input string what, input rsp_item_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected byte %h matched %b, got byte %h matched %b",
                  $time, what, want.out_byte, want.matched,
                  rsp_mon.out_byte, rsp_mon.matched);
   endtask

   // Responses are checked before requests, since a response never belongs to a
   // request accepted at the same edge.
   always @(posedge clock) begin
      req_item_type rq;
      rsp_item_type want;
      bit           due;
      if (reset) begin
         foreach (homophone_count[i]) homophone_count[i] = '0;
         expected_text_q.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_text_q.size() == 0) begin
               flag_mismatch("response with nothing expected", '0);
            end else begin
               want = expected_text_q.pop_front();
               if (rsp_mon.out_byte !== want.out_byte || rsp_mon.matched !== want.matched)
                  flag_mismatch("response mismatch", want);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            rq.req_type   = req_mon.req_type;
            rq.row        = req_mon.row;
            rq.letter     = req_mon.letter;
            rq.char_byte  = req_mon.char_byte;
            rq.text_start = req_mon.text_start;
            due = apply_request(rq, want);
            if (due) expected_text_q.push_back(want);
         end
      end
      pending_count = expected_text_q.size();
   end

endmodule

@@ test/tb_top.sv @@
module tb_top;
   import hsc_pkg::*;

   localparam int NUM_LETTERS    = 33;
   localparam int NUM_HOMOPHONES = 12;
   localparam int CYCLE_LIMIT    = 100000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int HOLD_CYCLES    = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatch_count;
   int   pending_count;
   int   cycle_count = 0;
   int   tx_idle_pct;
   int   rx_idle_pct;
   int   rx_hold_cycles = 0;

   // What the stimulus has loaded, used only to pick bytes that hit the tables.
   logic [BYTE_W-1:0] plain_shadow  [2][NUM_LETTERS];
   logic [BYTE_W-1:0] cipher_shadow [NUM_HOMOPHONES][NUM_LETTERS];
   int unsigned       seen_in_text  [NUM_LETTERS];

   hsc_req_if req_ch ();
   hsc_rsp_if rsp_ch ();

   homophonic_substitution_cipher #(
      .LETTERS    (NUM_LETTERS),
      .HOMOPHONES (NUM_HOMOPHONES)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   hsc_cipher_checker #(
      .LETTERS    (NUM_LETTERS),
      .HOMOPHONES (NUM_HOMOPHONES)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always #1 clock = ~clock;

   // Guard against a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Response side: random stalls, or a long hold-off counted down here.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            rx_hold_cycles--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Offers one transaction at the falling edge and returns once it is accepted.
   task automatic send_req(input logic [TYPE_W-1:0] kind, input logic [ROW_W-1:0] row,
                           input logic [LETTER_W-1:0] letter,
                           input logic [BYTE_W-1:0] value, input logic start);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      if (kind == REQ_LOAD_PLAIN && row <= LOWER_ROW && letter < NUM_LETTERS)
         plain_shadow[row][letter] = value;
      if (kind == REQ_LOAD_CIPHER && row < NUM_HOMOPHONES && letter < NUM_LETTERS)
         cipher_shadow[row][letter] = value;
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= kind;
      req_ch.row        <= row;
      req_ch.letter     <= letter;
      req_ch.char_byte  <= value;
      req_ch.text_start <= start;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Stops offering and waits until every owed response has arrived.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Fills both tables, either spread over a byte range or from a few shared bytes.
   task automatic load_tables(input bit from_pool);
      logic [BYTE_W-1:0] pool [8];
      foreach (pool[p]) pool[p] = BYTE_W'($urandom_range(255));
      for (int r = 0; r < 2; r++)
         for (int l = 0; l < NUM_LETTERS; l++)
            send_req(REQ_LOAD_PLAIN, ROW_W'(r), LETTER_W'(l),
                     from_pool ? pool[$urandom_range(7)]
                               : BYTE_W'($urandom_range(8'hDF, 8'h20)), 1'b0);
      for (int r = 0; r < NUM_HOMOPHONES; r++)
         for (int l = 0; l < NUM_LETTERS; l++)
            send_req(REQ_LOAD_CIPHER, ROW_W'(r), LETTER_W'(l),
                     from_pool ? pool[$urandom_range(7)]
                               : BYTE_W'($urandom_range(8'hDF, 8'h20)), 1'b0);
   endtask

   // A table write with random content; a quarter may aim outside the tables.
   task automatic send_random_load();
      logic [TYPE_W-1:0]   kind;
      logic [ROW_W-1:0]    row;
      logic [LETTER_W-1:0] letter;
      logic                start;
      kind = $urandom_range(1) ? REQ_LOAD_CIPHER : REQ_LOAD_PLAIN;
      if ($urandom_range(3) == 0) begin
         row    = ROW_W'($urandom_range(15));
         letter = LETTER_W'($urandom_range(63));
      end else begin
         row    = ROW_W'((kind == REQ_LOAD_PLAIN) ? $urandom_range(1)
                                                  : $urandom_range(NUM_HOMOPHONES-1));
         letter = LETTER_W'($urandom_range(NUM_LETTERS-1));
      end
      start = ($urandom_range(7) == 0);
      if (start) seen_in_text = '{default: 0};
      send_req(kind, row, letter, BYTE_W'($urandom_range(255)), start);
   endtask

   // Random texts of table bytes, mostly well formed: decrypt bytes follow the
   // homophone sequence each letter would produce, with some noise mixed in.
   task automatic run_texts(input int n_items);
      int                sent;
      int                len;
      int                fav;
      int                pick;
      int                l;
      logic              start;
      logic [TYPE_W-1:0] kind;
      logic [BYTE_W-1:0] value;
      sent = 0;
      while (sent < n_items) begin
         len  = $urandom_range(48, 1);
         fav  = $urandom_range(NUM_LETTERS-1);
         pick = $urandom_range(9);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(99) < 5) begin
               send_random_load();
               sent++;
            end
            start = (k == 0) || ($urandom_range(199) == 0);
            if (start) seen_in_text = '{default: 0};
            if (pick < 4)
               kind = REQ_ENCRYPT;
            else if (pick < 8)
               kind = REQ_DECRYPT;
            else
               kind = $urandom_range(1) ? REQ_ENCRYPT : REQ_DECRYPT;
            l = $urandom_range(1) ? fav : $urandom_range(NUM_LETTERS-1);
            if ($urandom_range(99) < 8) begin
               value = BYTE_W'($urandom_range(255));
            end else begin
               if (kind == REQ_ENCRYPT)
                  value = plain_shadow[$urandom_range(1)][l];
               else
                  value = cipher_shadow[seen_in_text[l] % NUM_HOMOPHONES][l];
               seen_in_text[l]++;
            end
            send_req(kind, ROW_W'($urandom_range(15)), LETTER_W'($urandom_range(63)),
                     value, start);
            sent++;
         end
      end
   endtask

   // Main sequence.
   initial begin
      logic [BYTE_W-1:0] dup;
      req_ch.valid      = 1'b0;
      req_ch.req_type   = REQ_LOAD_PLAIN;
      req_ch.row        = '0;
      req_ch.letter     = '0;
      req_ch.char_byte  = '0;
      req_ch.text_start = 1'b0;
      tx_idle_pct = 7;
      rx_idle_pct = 45;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Every entry is written before any text is sent.
      load_tables(1'b0);

      // Corner letters of both rows.
      send_req(REQ_ENCRYPT, '0, '0, plain_shadow[UPPER_ROW][0], 1'b1);
      send_req(REQ_ENCRYPT, 4'hF, 6'h3F, plain_shadow[LOWER_ROW][NUM_LETTERS-1], 1'b0);
      send_req(REQ_DECRYPT, '0, '0, cipher_shadow[0][0], 1'b1);

      // Writes outside the tables must be dropped.
      send_req(REQ_LOAD_PLAIN, 4'hF, '0, 8'h00, 1'b0);
      send_req(REQ_LOAD_PLAIN, UPPER_ROW, LETTER_W'(NUM_LETTERS), 8'h00, 1'b0);
      send_req(REQ_LOAD_CIPHER, ROW_W'(NUM_HOMOPHONES), 6'h3F, 8'hFF, 1'b0);

      // The tables hold no 00 or FF yet, so these pass through unchanged.
      send_req(REQ_ENCRYPT, '0, '0, 8'h00, 1'b0);
      send_req(REQ_DECRYPT, '0, '0, 8'hFF, 1'b0);

      // Thirteen hits on one letter take its counter around.
      for (int k = 0; k < 13; k++)
         send_req(REQ_ENCRYPT, '0, '0, plain_shadow[UPPER_ROW][7], k == 0);

      // Two letters share a byte: both advance and the higher letter answers.
      dup = plain_shadow[UPPER_ROW][30];
      send_req(REQ_LOAD_PLAIN, LOWER_ROW, 6'd3, dup, 1'b0);
      send_req(REQ_ENCRYPT, '0, '0, dup, 1'b1);
      dup = cipher_shadow[0][31];
      send_req(REQ_LOAD_CIPHER, '0, 6'd4, dup, 1'b0);
      send_req(REQ_DECRYPT, '0, '0, dup, 1'b1);

      // A load that starts a text clears the counters as well.
      send_req(REQ_LOAD_PLAIN, UPPER_ROW, '0, plain_shadow[UPPER_ROW][0], 1'b1);
      send_req(REQ_ENCRYPT, '0, '0, plain_shadow[UPPER_ROW][0], 1'b0);

      run_texts(130);
      drain();

      // Crowded tables from a few shared bytes give many multiple matches.
      tx_idle_pct = 45;
      rx_idle_pct = 7;
      load_tables(1'b1);
      run_texts(130);
      drain();

      // No idling; the receiver holds off while requests keep coming.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      rx_hold_cycles = HOLD_CYCLES;
      run_texts(40);
      drain();
      run_texts(100);
      drain();

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/hsc_pkg.sv
hdl/hsc_if.sv
hdl/hsc_letter_lane.sv
hdl/hsc_select.sv
hdl/homophonic_substitution_cipher.sv
hdl/hsc_checker.sv
test/hsc_cipher_checker.sv
test/tb_top.sv
